// ===== rtl/msst_pkg.sv =====
`default_nettype none

package msst_pkg;

    localparam int MS_W   = 16;
    localparam int SLOT_W = 2;

    // Input item kinds
    localparam logic [1:0] KIND_TICK      = 2'd0;
    localparam logic [1:0] KIND_REG_ONCE  = 2'd1;
    localparam logic [1:0] KIND_REG_CYCLE = 2'd2;
    localparam logic [1:0] KIND_PROCESS   = 2'd3;

    // Slot modes
    localparam logic [1:0] MODE_INACTIVE = 2'd0;
    localparam logic [1:0] MODE_PERIODIC = 2'd1;
    localparam logic [1:0] MODE_ONE_SHOT = 2'd2;

    // Result kinds
    localparam logic RES_REGISTER = 1'b0;
    localparam logic RES_EXPIRY   = 1'b1;

    // Broadcast command from the controller to every cell
    typedef struct packed {
        logic              tick;
        logic              reg_go;
        logic              one_shot;
        logic [MS_W-1:0]   target;
        logic              notify;
    } cmd_t;

    // Result carried along the row of cells
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [MS_W-1:0]   elapsed;
        logic              last;
    } notice_t;

endpackage

`default_nettype wire

// ===== rtl/msst_cell.sv =====
`default_nettype none

module msst_cell
    import msst_pkg::*;
#(
    parameter int IDX = 0
)(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cmd_t    cmd,
    input  wire logic    tok_in,
    output logic         tok_out,
    input  wire logic    free_in,
    output logic         free_out,
    input  wire logic    later_in,
    output logic         later_out,
    input  wire notice_t grant_in,
    output notice_t      grant_out,
    input  wire notice_t note_in,
    output notice_t      note_out
);

    localparam logic [SLOT_W-1:0] SLOT_ID = SLOT_W'(IDX);

    logic [1:0]      mode_reg, mode_next;
    logic [MS_W-1:0] target_reg, target_next;
    logic [MS_W-1:0] elapsed_reg, elapsed_next;
    logic            notify_reg, notify_next;
    logic            tok_reg;

    logic active, inactive, due, claim, fire, emit;

    assign inactive = (mode_reg == MODE_INACTIVE);
    assign active   = (mode_reg == MODE_PERIODIC) || (mode_reg == MODE_ONE_SHOT);
    assign due      = active && (elapsed_reg >= target_reg);

    // Grant chain: the lowest free cell takes the registration
    assign claim    = cmd.reg_go && free_in && inactive;
    assign free_out = free_in && !inactive;

    // Scan token sits here for one cycle
    assign fire     = tok_reg && due;
    assign emit     = fire && notify_reg;

    // Tell lower cells whether a notice is still to come from here or above
    assign later_out = later_in || (due && notify_reg);

    assign tok_out = tok_reg;

    always_comb
    begin
        grant_out = grant_in;
        if (claim)
        begin
            grant_out.hit     = 1'b1;
            grant_out.slot    = SLOT_ID;
            grant_out.elapsed = '0;
            grant_out.last    = 1'b1;
        end
    end

    always_comb
    begin
        note_out = note_in;
        if (emit)
        begin
            note_out.hit     = 1'b1;
            note_out.slot    = SLOT_ID;
            note_out.elapsed = elapsed_reg;
            note_out.last    = !later_in;
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        target_next  = target_reg;
        elapsed_next = elapsed_reg;
        notify_next  = notify_reg;
        if (cmd.tick)
        begin
            elapsed_next = elapsed_reg + MS_W'(1);
        end
        if (claim)
        begin
            mode_next    = cmd.one_shot ? MODE_ONE_SHOT : MODE_PERIODIC;
            target_next  = cmd.target;
            elapsed_next = '0;
            notify_next  = cmd.notify;
        end
        if (fire)
        begin
            elapsed_next = '0;
            if (mode_reg == MODE_ONE_SHOT)
            begin
                mode_next = MODE_INACTIVE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_INACTIVE;
            elapsed_reg <= '0;
            tok_reg     <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            tok_reg     <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        notify_reg <= notify_next;
    end

endmodule

`default_nettype wire

// ===== rtl/multi_slot_software_timer.sv =====
`default_nettype none

// Bank of SLOTS software timer slots built as a row of identical cells, one
// per slot. A tick transaction advances every slot's elapsed count and
// gives no result. A register transaction is decided combinationally
// by a grant chain that runs from slot 0 upward; its answer appears on the
// result ports in the next cycle and busy stays low, so a new transaction
// may start right away. A process transaction launches a scan token that
// steps through one cell per cycle: busy is high while the token is in
// any cell, and each due slot with notify set puts one expiry notice on the
// result ports, in ascending slot order, in the cycle after the token visits
// it. Results are shown for exactly one cycle with strobe high and cannot
// be held off; last marks the final result of a transaction. A process
// transaction with nothing to report gives no result at all.
module multi_slot_software_timer
    import msst_pkg::*;
#(
    parameter int SLOTS = 4
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        kind,
    input  wire logic [MS_W-1:0]   target_ticks,
    input  wire logic              notify,
    output logic                   strobe,
    output logic                   result_kind,
    output logic                   accepted,
    output logic [SLOT_W-1:0]      slot,
    output logic [MS_W-1:0]        elapsed_ticks,
    output logic                   last
);

    logic    take;
    cmd_t    cmd;
    logic    launch;

    logic    [SLOTS-1:0] tok_bits;
    logic    free_c  [SLOTS+1];
    logic    later_c [SLOTS+1];
    notice_t grant_c [SLOTS+1];
    notice_t note_c  [SLOTS+1];

    logic              strobe_reg,  strobe_next;
    logic              rkind_reg,   rkind_next;
    logic              acc_reg,     acc_next;
    logic [SLOT_W-1:0] slot_reg,    slot_next;
    logic [MS_W-1:0]   elapsed_reg, elapsed_next;
    logic              last_reg,    last_next;

    // Accept a transaction only while no scan is in flight
    assign busy = |tok_bits;
    assign take = start && !busy;

    always_comb
    begin
        cmd.tick     = take && (kind == KIND_TICK);
        cmd.reg_go   = take && ((kind == KIND_REG_ONCE) || (kind == KIND_REG_CYCLE));
        cmd.one_shot = (kind == KIND_REG_ONCE);
        cmd.target   = target_ticks;
        cmd.notify   = notify;
    end

    // Drop the scan token into slot 0
    assign launch = take && (kind == KIND_PROCESS);

    // Chain ends: the grant and notice chains start empty at slot 0, the
    // look-ahead for pending notices starts empty above the top slot
    assign free_c[0]      = 1'b1;
    assign grant_c[0]     = '0;
    assign note_c[0]      = '0;
    assign later_c[SLOTS] = 1'b0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic tok_in_w;
        if (i == 0)
        begin : g_head
            assign tok_in_w = launch;
        end
        else
        begin : g_body
            assign tok_in_w = tok_bits[i-1];
        end

        msst_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .tok_in    (tok_in_w),
            .tok_out   (tok_bits[i]),
            .free_in   (free_c[i]),
            .free_out  (free_c[i+1]),
            .later_in  (later_c[i+1]),
            .later_out (later_c[i]),
            .grant_in  (grant_c[i]),
            .grant_out (grant_c[i+1]),
            .note_in   (note_c[i]),
            .note_out  (note_c[i+1])
        );
    end

    // Result register: a registration answer or the notice from the cell
    // that holds the scan token this cycle; the two never coincide
    always_comb
    begin
        strobe_next  = 1'b0;
        rkind_next   = RES_REGISTER;
        acc_next     = 1'b0;
        slot_next    = '0;
        elapsed_next = '0;
        last_next    = 1'b0;
        if (cmd.reg_go)
        begin
            strobe_next = 1'b1;
            acc_next    = grant_c[SLOTS].hit;
            slot_next   = grant_c[SLOTS].slot;
            last_next   = 1'b1;
        end
        else if (note_c[SLOTS].hit)
        begin
            strobe_next  = 1'b1;
            rkind_next   = RES_EXPIRY;
            acc_next     = 1'b1;
            slot_next    = note_c[SLOTS].slot;
            elapsed_next = note_c[SLOTS].elapsed;
            last_next    = note_c[SLOTS].last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rkind_reg   <= rkind_next;
        acc_reg     <= acc_next;
        slot_reg    <= slot_next;
        elapsed_reg <= elapsed_next;
        last_reg    <= last_next;
    end

    assign strobe        = strobe_reg;
    assign result_kind   = rkind_reg;
    assign accepted      = acc_reg;
    assign slot          = slot_reg;
    assign elapsed_ticks = elapsed_reg;
    assign last          = last_reg;

`ifndef NO_ASSERTIONS
    // At most one cell holds the scan token
    a_token_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_bits))
        else $error("scan token held by more than one cell");

    // A registration answer follows an accepted register transaction
    a_reg_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (result_kind == RES_REGISTER)) |->
        $past(start && !busy && ((kind == KIND_REG_ONCE) || (kind == KIND_REG_CYCLE))))
        else $error("registration answer without a register transaction");

    // A registration answer is always the final result
    a_reg_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (result_kind == RES_REGISTER)) |-> last)
        else $error("registration answer not marked last");

    // Expiry notices only come out of a running scan
    a_notice_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (result_kind == RES_EXPIRY)) |-> $past(busy))
        else $error("expiry notice outside a scan");
`endif

endmodule

`default_nettype wire
